// ===== rtl/axis_angle_rotation_matrix_macros.svh =====
// Assertion macros used by the checker file.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define AARM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define AARM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/aarm_pkg.sv =====
`timescale 1ns / 1ps

package aarm_pkg;

	// Q2.30 intermediate with headroom for angle reduction and sums.
	typedef logic signed [35:0] q30_t;
	typedef logic signed [15:0] comp_t;
	typedef logic signed [31:0] unit_t;

	localparam q30_t Q30_ONE     = 36'sd1073741824;
	localparam q30_t Q30_PI      = 36'sd3373259426;
	localparam q30_t Q30_TWO_PI  = 36'sd6746518852;
	localparam q30_t Q30_HALF_PI = 36'sd1686629713;
	localparam q30_t Q30_GAIN    = 36'sd652032874;

	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 48;
	localparam int RSQ_W       = 48;

	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'h3243F6A8;
			5'd1: r = 32'h1DAC6705;
			5'd2: r = 32'h0FADBAFC;
			5'd3: r = 32'h07F56EA6;
			5'd4: r = 32'h03FEAB76;
			5'd5: r = 32'h01FFD55B;
			5'd6: r = 32'h00FFFAAA;
			5'd7: r = 32'h007FFF55;
			5'd8: r = 32'h003FFFEA;
			5'd9: r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/aarm_cordic.sv =====
`timescale 1ns / 1ps

// Angle reduction in two stages, then one rotation-mode CORDIC step per stage.
module aarm_cordic #(
	parameter int NIT = 16
) (
	input  logic           clk,
	input  logic           en,
	input  aarm_pkg::comp_t angle,
	output aarm_pkg::unit_t sn,
	output aarm_pkg::unit_t cs
);

	aarm_pkg::q30_t a0;
	aarm_pkg::q30_t a_s1;
	aarm_pkg::q30_t a_s2;
	logic           flip_s2;

	aarm_pkg::q30_t x_s [1:NIT];
	aarm_pkg::q30_t y_s [1:NIT];
	aarm_pkg::q30_t z_s [1:NIT];
	logic           fl_s [1:NIT];

	assign a0 = {{2{angle[15]}}, angle, 18'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			if (a0 > aarm_pkg::Q30_PI) begin
				a_s1 <= a0 - aarm_pkg::Q30_TWO_PI;
			end else if (a0 < -aarm_pkg::Q30_PI) begin
				a_s1 <= a0 + aarm_pkg::Q30_TWO_PI;
			end else begin
				a_s1 <= a0;
			end
			if (a_s1 > aarm_pkg::Q30_HALF_PI) begin
				a_s2    <= aarm_pkg::Q30_PI - a_s1;
				flip_s2 <= 1'b1;
			end else if (a_s1 < -aarm_pkg::Q30_HALF_PI) begin
				a_s2    <= -aarm_pkg::Q30_PI - a_s1;
				flip_s2 <= 1'b1;
			end else begin
				a_s2    <= a_s1;
				flip_s2 <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < NIT; k++) begin : g_step
		aarm_pkg::q30_t xi, yi, zi, at;
		logic           fi;
		if (k == 0) begin : g_first
			assign xi = aarm_pkg::Q30_GAIN;
			assign yi = '0;
			assign zi = a_s2;
			assign fi = flip_s2;
		end else begin : g_next
			assign xi = x_s[k];
			assign yi = y_s[k];
			assign zi = z_s[k];
			assign fi = fl_s[k];
		end
		assign at = aarm_pkg::q30_t'({4'b0, aarm_pkg::atan_q30(5'(k))});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[35]) begin
					x_s[k+1] <= xi - (yi >>> k);
					y_s[k+1] <= yi + (xi >>> k);
					z_s[k+1] <= zi - at;
				end else begin
					x_s[k+1] <= xi + (yi >>> k);
					y_s[k+1] <= yi - (xi >>> k);
					z_s[k+1] <= zi + at;
				end
				fl_s[k+1] <= fi;
			end
		end
	end

	assign sn = aarm_pkg::unit_t'(y_s[NIT]);
	assign cs = fl_s[NIT] ? aarm_pkg::unit_t'(-x_s[NIT]) : aarm_pkg::unit_t'(x_s[NIT]);

endmodule

// ===== rtl/aarm_rsqrt.sv =====
`timescale 1ns / 1ps

// 2^62 / floor(sqrt(s * 2^30)): one root bit per stage, then one quotient bit per stage.
module aarm_rsqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [31:0]                  s,
	output logic [aarm_pkg::RSQ_W-1:0]   rsq
);

	localparam int NS = aarm_pkg::SQRT_STAGES;
	localparam int ND = aarm_pkg::DIV_STAGES;

	logic [63:0] v_s   [1:NS];
	logic [63:0] res_s [1:NS];

	logic [31:0]               rem_s  [1:ND];
	logic [31:0]               root_s [1:ND];
	logic [aarm_pkg::RSQ_W-1:0] q_s   [1:ND];

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		logic [63:0] vi, ri, bitv, trial;
		if (j == 0) begin : g_first
			assign vi = {2'b0, s, 30'b0};
			assign ri = '0;
		end else begin : g_next
			assign vi = v_s[j];
			assign ri = res_s[j];
		end
		assign bitv  = 64'd1 << (62 - 2 * j);
		assign trial = ri + bitv;
		always_ff @(posedge clk) begin
			if (en) begin
				if (vi >= trial) begin
					v_s[j+1]   <= vi - trial;
					res_s[j+1] <= (ri >> 1) + bitv;
				end else begin
					v_s[j+1]   <= vi;
					res_s[j+1] <= ri >> 1;
				end
			end
		end
	end

	for (genvar k = 0; k < ND; k++) begin : g_div
		logic [31:0]                remi, rooti, trial;
		logic [aarm_pkg::RSQ_W-1:0] qi;
		if (k == 0) begin : g_first
			assign remi  = 32'd1 << 14;
			assign rooti = res_s[NS][31:0];
			assign qi    = '0;
		end else begin : g_next
			assign remi  = rem_s[k];
			assign rooti = root_s[k];
			assign qi    = q_s[k];
		end
		assign trial = {remi[30:0], 1'b0};
		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= rooti;
				if (trial >= rooti) begin
					rem_s[k+1] <= trial - rooti;
					q_s[k+1]   <= {qi[aarm_pkg::RSQ_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial;
					q_s[k+1]   <= {qi[aarm_pkg::RSQ_W-2:0], 1'b0};
				end
			end
		end
	end

	assign rsq = q_s[ND];

endmodule

// ===== rtl/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// The delay from an input transfer to its result is the same for any TRIG_ITERATIONS.
// Throughput: one transfer per cycle when not stalled; every stage holds one item,
// so the rate is set by the fully pipelined CORDIC, square root and divider chains.
// The whole pipeline advances together and holds while a result waits unread.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.

// Axis-angle to 3x3 rotation matrix, row-vector layout, entries in Q1.14 by default.
//
// Stage map:
//   1          : squared axis length, zero-axis detect.
//   2..33      : digit-by-digit square root of s * 2^30 (in aarm_rsqrt).
//   34..81     : restoring divide 2^62 / root, one quotient bit a stage.
//   82..83     : unit axis components, split 16x24 partial products.
//   84         : pairwise axis products and axis times sine.
//   85         : pairwise products times (1 - cos).
//   86         : entry sums.
//   87         : rounding, saturation, identity on a zero axis; output register.
// The angle runs through reduction and the CORDIC in parallel and is then
// delayed to meet the normalized axis at stage 83.
module axis_angle_rotation_matrix #(
	parameter int FRACTION_BITS   = 14,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// Fields from bit 0 up: axis_x, axis_y, axis_z, angle.
	input  logic [63:0]   s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// Fields from bit 0 up: m00, m01, m02, m10, m11, m12, m20, m21, m22.
	output logic [143:0]  m_axis_tdata,
	// Fields from bit 0 up: zero_axis.
	output logic [0:0]    m_axis_tuser
);

	localparam int NIT   = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
	localparam int RS    = aarm_pkg::SQRT_STAGES + aarm_pkg::DIV_STAGES;
	localparam int LAT   = RS + 7;
	// Axis values ride from stage 1 to the stage where the reciprocal emerges.
	localparam int AXD   = RS + 1;
	// Trig results delay from the CORDIC output to the normalized-axis stage.
	localparam int TD    = RS + 3 - (2 + NIT);
	localparam int SH    = 30 - FRACTION_BITS;

	localparam logic signed [36:0] HALF = (37'sd1 <<< SH) >>> 1;
	localparam logic signed [36:0] LIM  = 37'sd1 <<< FRACTION_BITS;

	function automatic logic [15:0] finish(input aarm_pkg::q30_t v);
		logic signed [36:0] r;
		r = 37'(v) + HALF;
		r = r >>> SH;
		if (r > LIM) r = LIM;
		if (r < -LIM) r = -LIM;
		if (r > 37'sd32767) r = 37'sd32767;
		if (r < -37'sd32768) r = -37'sd32768;
		return r[15:0];
	endfunction

	localparam logic [15:0] DIAG = finish(aarm_pkg::Q30_ONE);

	logic en;
	logic v_s [1:LAT];
	logic zf_s [1:LAT];

	aarm_pkg::comp_t ax, ay, az, angle;
	assign ax    = s_axis_tdata[15:0];
	assign ay    = s_axis_tdata[31:16];
	assign az    = s_axis_tdata[47:32];
	assign angle = s_axis_tdata[63:48];

	// The pipeline moves whenever the output register is empty or being read.
	assign en            = !v_s[LAT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= LAT; k++) v_s[k] <= v_s[k-1];
		end
	end

	// Stage 1: squared length, zero-axis flag and the axis delay line. Each square
	// is formed at 32 bits; the sum of three may exceed the signed range but its
	// bits are the unsigned length.
	logic [31:0]     s_s1;
	aarm_pkg::comp_t axd_s [1:AXD];
	aarm_pkg::comp_t ayd_s [1:AXD];
	aarm_pkg::comp_t azd_s [1:AXD];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1 <= 32'(32'(ax) * 32'(ax)) + 32'(32'(ay) * 32'(ay)) +
				32'(32'(az) * 32'(az));
			zf_s[1] <= (ax == 16'sd0) && (ay == 16'sd0) && (az == 16'sd0);
			for (int k = 2; k <= LAT; k++) zf_s[k] <= zf_s[k-1];
			axd_s[1] <= ax;
			ayd_s[1] <= ay;
			azd_s[1] <= az;
			for (int k = 2; k <= AXD; k++) begin
				axd_s[k] <= axd_s[k-1];
				ayd_s[k] <= ayd_s[k-1];
				azd_s[k] <= azd_s[k-1];
			end
		end
	end

	logic [aarm_pkg::RSQ_W-1:0] rsq;

	aarm_rsqrt u_rsqrt (
		.clk (clk),
		.en  (en),
		.s   (s_s1),
		.rsq (rsq)
	);

	// Trig path and its alignment delay.
	aarm_pkg::unit_t sn_c, cs_c;
	aarm_pkg::unit_t sn_d [0:TD-1];
	aarm_pkg::unit_t cs_d [0:TD-1];

	aarm_cordic #(.NIT(NIT)) u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (angle),
		.sn    (sn_c),
		.cs    (cs_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sn_d[0] <= sn_c;
			cs_d[0] <= cs_c;
			for (int k = 1; k < TD; k++) begin
				sn_d[k] <= sn_d[k-1];
				cs_d[k] <= cs_d[k-1];
			end
		end
	end

	// Unit components: |a| * rsq >> 17 with the sign restored.
	logic [15:0] magx, magy, magz;
	assign magx = axd_s[AXD][15] ? 16'(-axd_s[AXD]) : 16'(axd_s[AXD]);
	assign magy = ayd_s[AXD][15] ? 16'(-ayd_s[AXD]) : 16'(ayd_s[AXD]);
	assign magz = azd_s[AXD][15] ? 16'(-azd_s[AXD]) : 16'(azd_s[AXD]);

	logic [39:0] phx_s1u, plx_s1u, phy_s1u, ply_s1u, phz_s1u, plz_s1u;
	logic        sgx_s1u, sgy_s1u, sgz_s1u;
	aarm_pkg::unit_t nx_s2u, ny_s2u, nz_s2u;
	logic [63:0] fx, fy, fz;

	assign fx = {phx_s1u, 24'b0} + 64'(plx_s1u);
	assign fy = {phy_s1u, 24'b0} + 64'(ply_s1u);
	assign fz = {phz_s1u, 24'b0} + 64'(plz_s1u);

	always_ff @(posedge clk) begin
		if (en) begin
			phx_s1u <= magx * rsq[47:24];
			plx_s1u <= magx * rsq[23:0];
			phy_s1u <= magy * rsq[47:24];
			ply_s1u <= magy * rsq[23:0];
			phz_s1u <= magz * rsq[47:24];
			plz_s1u <= magz * rsq[23:0];
			sgx_s1u <= axd_s[AXD][15];
			sgy_s1u <= ayd_s[AXD][15];
			sgz_s1u <= azd_s[AXD][15];
			nx_s2u  <= sgx_s1u ? -aarm_pkg::unit_t'(fx[48:17]) : aarm_pkg::unit_t'(fx[48:17]);
			ny_s2u  <= sgy_s1u ? -aarm_pkg::unit_t'(fy[48:17]) : aarm_pkg::unit_t'(fy[48:17]);
			nz_s2u  <= sgz_s1u ? -aarm_pkg::unit_t'(fz[48:17]) : aarm_pkg::unit_t'(fz[48:17]);
		end
	end

	// Products. All Q2.30 products are floored by an arithmetic shift of 30.
	aarm_pkg::unit_t sn83, cs83;
	assign sn83 = sn_d[TD-1];
	assign cs83 = cs_d[TD-1];

	logic signed [63:0] mxx, myy, mzz, mxy, mxz, myz, msx, msy, msz;
	assign mxx = nx_s2u * nx_s2u;
	assign myy = ny_s2u * ny_s2u;
	assign mzz = nz_s2u * nz_s2u;
	assign mxy = nx_s2u * ny_s2u;
	assign mxz = nx_s2u * nz_s2u;
	assign myz = ny_s2u * nz_s2u;
	assign msx = nx_s2u * sn83;
	assign msy = ny_s2u * sn83;
	assign msz = nz_s2u * sn83;

	aarm_pkg::unit_t pxx_p1, pyy_p1, pzz_p1, pxy_p1, pxz_p1, pyz_p1;
	aarm_pkg::unit_t sx_p1, sy_p1, sz_p1, cs_p1;
	logic signed [32:0] t_p1;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_p1 <= aarm_pkg::unit_t'(mxx >>> 30);
			pyy_p1 <= aarm_pkg::unit_t'(myy >>> 30);
			pzz_p1 <= aarm_pkg::unit_t'(mzz >>> 30);
			pxy_p1 <= aarm_pkg::unit_t'(mxy >>> 30);
			pxz_p1 <= aarm_pkg::unit_t'(mxz >>> 30);
			pyz_p1 <= aarm_pkg::unit_t'(myz >>> 30);
			sx_p1  <= aarm_pkg::unit_t'(msx >>> 30);
			sy_p1  <= aarm_pkg::unit_t'(msy >>> 30);
			sz_p1  <= aarm_pkg::unit_t'(msz >>> 30);
			cs_p1  <= cs83;
			t_p1   <= 33'sd1073741824 - 33'(cs83);
		end
	end

	logic signed [64:0] txx, tyy, tzz, txy, txz, tyz;
	assign txx = pxx_p1 * t_p1;
	assign tyy = pyy_p1 * t_p1;
	assign tzz = pzz_p1 * t_p1;
	assign txy = pxy_p1 * t_p1;
	assign txz = pxz_p1 * t_p1;
	assign tyz = pyz_p1 * t_p1;

	aarm_pkg::q30_t qxx_p2, qyy_p2, qzz_p2, qxy_p2, qxz_p2, qyz_p2;
	aarm_pkg::q30_t sx_p2, sy_p2, sz_p2, cs_p2;

	always_ff @(posedge clk) begin
		if (en) begin
			qxx_p2 <= aarm_pkg::q30_t'(txx >>> 30);
			qyy_p2 <= aarm_pkg::q30_t'(tyy >>> 30);
			qzz_p2 <= aarm_pkg::q30_t'(tzz >>> 30);
			qxy_p2 <= aarm_pkg::q30_t'(txy >>> 30);
			qxz_p2 <= aarm_pkg::q30_t'(txz >>> 30);
			qyz_p2 <= aarm_pkg::q30_t'(tyz >>> 30);
			sx_p2  <= aarm_pkg::q30_t'(sx_p1);
			sy_p2  <= aarm_pkg::q30_t'(sy_p1);
			sz_p2  <= aarm_pkg::q30_t'(sz_p1);
			cs_p2  <= aarm_pkg::q30_t'(cs_p1);
		end
	end

	// Entry sums in the row-vector layout.
	aarm_pkg::q30_t e_f1 [0:8];

	always_ff @(posedge clk) begin
		if (en) begin
			e_f1[0] <= qxx_p2 + cs_p2;
			e_f1[1] <= qxy_p2 + sz_p2;
			e_f1[2] <= qxz_p2 - sy_p2;
			e_f1[3] <= qxy_p2 - sz_p2;
			e_f1[4] <= qyy_p2 + cs_p2;
			e_f1[5] <= qyz_p2 + sx_p2;
			e_f1[6] <= qxz_p2 + sy_p2;
			e_f1[7] <= qyz_p2 - sx_p2;
			e_f1[8] <= qzz_p2 + cs_p2;
		end
	end

	// Output register: rounded entries, or the identity for a zero axis.
	logic [15:0] m_f2 [0:8];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				if (zf_s[LAT-1]) begin
					m_f2[k] <= (k % 4 == 0) ? DIAG : 16'd0;
				end else begin
					m_f2[k] <= finish(e_f1[k]);
				end
			end
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_out
		assign m_axis_tdata[16*k +: 16] = m_f2[k];
	end
	assign m_axis_tuser[0] = zf_s[LAT];

endmodule

// ===== rtl/aarm_checker.sv =====
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_macros.svh"

module aarm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	// A stalled result stays offered.
	`AARM_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`AARM_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// A stall at the output freezes the whole pipeline, so no input is taken.
	`AARM_ASSERT_SAME(a_stall_back, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

	// A zero axis gives the identity, so all off-diagonal entries are zero.
	`AARM_ASSERT_SAME(a_zero_ident, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:16] == 16'd0 && m_axis_tdata[47:32] == 16'd0 && m_axis_tdata[63:48] == 16'd0 && m_axis_tdata[95:80] == 16'd0 && m_axis_tdata[111:96] == 16'd0 && m_axis_tdata[127:112] == 16'd0, "zero axis without identity")

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== test/axis_angle_rotation_matrix_test.sv =====
`timescale 1ns / 1ps

// Stream-level check of the axis-angle rotation matrix block. Every input transfer is
// run through a local fixed-point model (angle reduction, CORDIC, root and divide
// normalization, Rodrigues products) and the outputs are compared in order.
module axis_angle_rotation_matrix_test;

	localparam int FRAC = 14;
	localparam int ITERS = 16;
	localparam int LATENCY = 87;
	localparam int RANDOM_ITEMS = 1100;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [15:0] angle;
		logic signed [15:0] az;
		logic signed [15:0] ay;
		logic signed [15:0] ax;
	} pose_t;

	typedef struct {
		logic [143:0] entries;
		logic         zero_axis;
	} matrix_t;

	// Directed row: a pose and, where the answer is obvious, the matrix it must give.
	typedef struct {
		pose_t        pose;
		bit           typed;
		logic [143:0] entries;
		logic         zero_axis;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	axis_angle_rotation_matrix #(
		.FRACTION_BITS(FRAC),
		.TRIG_ITERATIONS(ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	matrix_t pending_matrices[$];
	int      mismatches = 0;
	int      sent = 0;
	int      idle_cycles = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	bit      hold_off = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint floor_shift(input longint v, input int sh);
		return v >>> sh;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned res, bit_val;
		res = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > v)
			bit_val >>= 2;
		while (bit_val != 0) begin
			if (v >= res + bit_val) begin
				v -= res + bit_val;
				res = (res >> 1) + bit_val;
			end else begin
				res >>= 1;
			end
			bit_val >>= 2;
		end
		return res;
	endfunction

	// Q2.30 to the output format: round half up, clamp to plus or minus one.
	function automatic logic [15:0] to_entry(input longint q);
		longint v, lim;
		lim = longint'(1) << FRAC;
		v = floor_shift(q + (longint'(1) << (30 - FRAC - 1)), 30 - FRAC);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic longint unit_part(input longint v, input longint unsigned rsq);
		longint unsigned mag;
		longint n;
		mag = (v < 0) ? -v : v;
		n = longint'((mag * rsq) >> 17);
		return (v < 0) ? -n : n;
	endfunction

	function automatic matrix_t rotation_of(input pose_t p);
		matrix_t r;
		longint ax, ay, az, a, x, y, z, dx, dy, sn, cs, t, nx, ny, nz, pxy, pxz, pyz;
		longint unsigned sq, root, rsq;
		longint q[9];
		bit flip;
		ax = p.ax;
		ay = p.ay;
		az = p.az;
		a = longint'(p.angle) * (longint'(1) << 18);
		flip = 0;
		if (ax == 0 && ay == 0 && az == 0) begin
			for (int i = 0; i < 9; i++)
				r.entries[i*16 +: 16] = to_entry((i % 4 == 0) ?
					longint'(aarm_pkg::Q30_ONE) : 0);
			r.zero_axis = 1'b1;
			return r;
		end
		// Wrap to [-pi, pi], then fold into [-pi/2, pi/2] flipping the cosine.
		if (a > longint'(aarm_pkg::Q30_PI)) a -= 2 * longint'(aarm_pkg::Q30_PI);
		if (a < -longint'(aarm_pkg::Q30_PI)) a += 2 * longint'(aarm_pkg::Q30_PI);
		if (a > longint'(aarm_pkg::Q30_HALF_PI)) begin
			a = longint'(aarm_pkg::Q30_PI) - a;
			flip = 1;
		end else if (a < -longint'(aarm_pkg::Q30_HALF_PI)) begin
			a = -longint'(aarm_pkg::Q30_PI) - a;
			flip = 1;
		end
		x = aarm_pkg::Q30_GAIN;
		y = 0;
		z = a;
		for (int i = 0; i < ITERS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(aarm_pkg::atan_q30(i[4:0]));
			end else begin
				x += dx; y -= dy; z += longint'(aarm_pkg::atan_q30(i[4:0]));
			end
		end
		sn = y;
		cs = flip ? -x : x;
		t = longint'(aarm_pkg::Q30_ONE) - cs;
		sq = ax * ax + ay * ay + az * az;
		root = int_sqrt(sq << 30);
		rsq = (64'd1 << 62) / root;
		nx = unit_part(ax, rsq);
		ny = unit_part(ay, rsq);
		nz = unit_part(az, rsq);
		pxy = q30_mul(q30_mul(nx, ny), t);
		pxz = q30_mul(q30_mul(nx, nz), t);
		pyz = q30_mul(q30_mul(ny, nz), t);
		q[0] = q30_mul(q30_mul(nx, nx), t) + cs;
		q[1] = pxy + q30_mul(nz, sn);
		q[2] = pxz - q30_mul(ny, sn);
		q[3] = pxy - q30_mul(nz, sn);
		q[4] = q30_mul(q30_mul(ny, ny), t) + cs;
		q[5] = pyz + q30_mul(nx, sn);
		q[6] = pxz + q30_mul(ny, sn);
		q[7] = pyz - q30_mul(nx, sn);
		q[8] = q30_mul(q30_mul(nz, nz), t) + cs;
		for (int i = 0; i < 9; i++)
			r.entries[i*16 +: 16] = to_entry(q[i]);
		r.zero_axis = 1'b0;
		return r;
	endfunction

	function automatic logic [143:0] identity_entries();
		logic [143:0] e;
		e = '0;
		e[0 +: 16] = 16'sd16384;
		e[64 +: 16] = 16'sd16384;
		e[128 +: 16] = 16'sd16384;
		return e;
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		p.ax = 16'($urandom);
		p.ay = 16'($urandom);
		p.az = 16'($urandom);
		p.angle = 16'($urandom);
		// Small axes exercise the normalization at its coarsest; a few zero axes too.
		case ($urandom_range(0, 9))
			0: begin p.ax = 16'($urandom_range(0, 6) - 3); p.ay = 16'($urandom_range(0, 6) - 3);
				p.az = 16'($urandom_range(0, 6) - 3); end
			1: begin p.ax = 0; p.ay = 0; p.az = 0; end
			2: begin p.ay = 0; p.az = 0; end
			default: ;
		endcase
		return p;
	endfunction

	// Drives one transfer and queues its expected matrix on acceptance. Valid stays
	// high into a following transfer and drops only in an idle cycle or at the end.
	task automatic send_pose(input pose_t p, input matrix_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_matrices.push_back(want);
		sent++;
		@(negedge clk);
	endtask

	// Receiver side: random stalls, plus a long hold-off while hold_off is set.
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		matrix_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_matrices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %h", m_axis_tdata);
			end else begin
				want = pending_matrices.pop_front();
				for (int i = 0; i < 9; i++)
					if (m_axis_tdata[i*16 +: 16] !== want.entries[i*16 +: 16]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("entry m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
								$signed(want.entries[i*16 +: 16]),
								$signed(m_axis_tdata[i*16 +: 16]));
					end
				if (m_axis_tuser[0] !== want.zero_axis) begin
					mismatches++;
					if (mismatches <= 10)
						$display("zero_axis: expected %b, got %b", want.zero_axis,
							m_axis_tuser[0]);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		matrix_t want;
		int phase_pcts[4][2];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		phase_pcts = '{'{0, 0}, '{73, 0}, '{0, 73}, '{16, 16}};

		// Zero axis with extreme angles gives the identity and the flag.
		r = '{pose: {16'sh7FFF, 16'sd0, 16'sd0, 16'sd0}, typed: 1,
			entries: identity_entries(), zero_axis: 1};
		rows.push_back(r);
		r.pose = {16'sh8000, 16'sd0, 16'sd0, 16'sd0};
		rows.push_back(r);
		// Zero angle about any axis is also the identity, without the flag.
		r = '{pose: {16'sd0, 16'sd0, 16'sd0, 16'sd1}, typed: 1,
			entries: identity_entries(), zero_axis: 0};
		rows.push_back(r);
		r.pose = {16'sd0, 16'sh8000, 16'sh7FFF, 16'sh8000};
		rows.push_back(r);
		// Remaining rows: unit axes, extreme components, quarter and half turns,
		// angles on both sides of the wrap and fold points.
		r.typed = 0;
		r.pose = {16'sd6434, 16'sd0, 16'sd0, 16'sd1};        rows.push_back(r);
		r.pose = {16'sd6434, 16'sd0, 16'sd1, 16'sd0};        rows.push_back(r);
		r.pose = {16'sd6434, 16'sd1, 16'sd0, 16'sd0};        rows.push_back(r);
		r.pose = {16'sd12868, 16'sd0, 16'sd0, 16'sh8000};    rows.push_back(r);
		r.pose = {-16'sd12868, 16'sh7FFF, 16'sd0, 16'sd0};   rows.push_back(r);
		r.pose = {16'sd12867, 16'sh8000, 16'sh8000, 16'sh8000}; rows.push_back(r);
		r.pose = {16'sd12869, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; rows.push_back(r);
		r.pose = {16'sd6433, 16'sd1, 16'sd1, 16'sd1};        rows.push_back(r);
		r.pose = {-16'sd6435, -16'sd1, 16'sd2, -16'sd3};     rows.push_back(r);
		r.pose = {16'sh7FFF, 16'sd3, -16'sd5, 16'sd7};       rows.push_back(r);
		r.pose = {16'sh8000, 16'sh5555, 16'shAAAA, 16'sh1234}; rows.push_back(r);
		r.pose = {16'sd4096, 16'shFFFF, 16'shFFFF, 16'shFFFF}; rows.push_back(r);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			want = rotation_of(rows[i].pose);
			if (rows[i].typed) begin
				want.entries = rows[i].entries;
				want.zero_axis = rows[i].zero_axis;
			end
			send_pose(rows[i].pose, want);
		end

		// Long receiver hold-off while poses keep coming, to fill the pipeline.
		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 150; i++) begin
				pose_t p;
				p = random_pose();
				send_pose(p, rotation_of(p));
			end
		join

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_pcts[ph][0];
			recv_stall_pct = phase_pcts[ph][1];
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				pose_t p;
				p = random_pose();
				send_pose(p, rotation_of(p));
			end
		end
		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;

		while (pending_matrices.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_cordic.sv
rtl/aarm_rsqrt.sv
rtl/axis_angle_rotation_matrix.sv
rtl/aarm_checker.sv
test/axis_angle_rotation_matrix_test.sv
